// ===== rtl/fstp_pkg.sv =====
// Package with constants, register indexes and helpers of the frame step timing policy.
`timescale 1ns / 1ps
package fstp_pkg;

   localparam int MAX_HISTORY_DEF = 32;

   localparam int FRAME_W = 20;
   localparam int COUNT_W = 20;
   localparam int STEP_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TARGET_STEP = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HISTORY_LEN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TRIM_COUNT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BLEND_RATE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_PAYBACK_RATE = 3'd5;

   localparam logic [1:0] MODE_VARIABLE = 2'd0;
   localparam logic [1:0] MODE_FIXED = 2'd1;
   localparam logic [1:0] MODE_SMOOTHED = 2'd2;
   localparam logic [1:0] MODE_PAYBACK = 2'd3;

   localparam logic [19:0] TARGET_STEP_RST = 20'd16667;
   localparam logic [5:0] HISTORY_LEN_RST = 6'd1;
   localparam logic [16:0] BLEND_RATE_ONE = 17'd65536;
   localparam logic [15:0] PAYBACK_RATE_RST = 16'd4096;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/frame_step_timing_policy_top.sv =====
// Top level of the frame step timing policy: sequencer, shared divider and multiplier.
// Variable mode passes each item straight through; fixed mode runs it through the
// shared restoring divider, one quotient bit per cycle; in the smoothed modes the rank
// of each held sample is counted against a rotating history ring, one comparison per
// cycle, before the divider forms the trimmed mean and the shared multiplier blends it.
// The block takes one item at a time; a finished result waits in the output register
// while the next item is accepted.
`timescale 1ns / 1ps
module frame_step_timing_policy_top #(
   parameter int MAX_HISTORY = fstp_pkg::MAX_HISTORY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [fstp_pkg::FRAME_W-1:0] req_frame_us,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [fstp_pkg::COUNT_W-1:0] rsp_step_count,
   output logic signed [fstp_pkg::STEP_W-1:0] rsp_step_us,
   input  logic csr_we,
   input  logic [fstp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [fstp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fstp_pkg::*;

   localparam int FW = $clog2(MAX_HISTORY + 1);
   localparam int IW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int SW = FRAME_W + FW;
   localparam int DW = (SW + 1 > 22) ? SW + 1 : 22;
   localparam int CW = $clog2(DW + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_ACC = 3'd4;
   localparam logic [2:0] S_DIV = 3'd5;
   localparam logic [2:0] S_MUL = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   logic [1:0] mode_ff;
   logic [19:0] target_ff;
   logic [5:0] hlen_ff;
   logic [3:0] trim_ff;
   logic [16:0] blend_ff;
   logic [15:0] pay_ff;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [FRAME_W-1:0] hist_ff [MAX_HISTORY];
   logic [FW-1:0] fill_ff, fill_in;
   logic [20:0] rem_ff, rem_in;
   logic signed [31:0] debt_ff, debt_in;
   logic [FRAME_W-1:0] cand_ff, cand_in;
   logic [FW-1:0] i_ff, i_in, j_ff, j_in, rank_ff, rank_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [DW-1:0] dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic signed [50:0] mp_ff, mp_in;
   logic [20:0] s_ff, s_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic signed [31:0] res_step_ff, res_step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic signed [31:0] rsp_step_ff, rsp_step_in;

   logic accept;
   logic [FW-1:0] len;
   logic [19:0] tstep;
   logic [16:0] rate;
   logic [6:0] need;
   logic [FW-1:0] keep;
   logic [DW:0] rt;
   logic [DW:0] rt_sub;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [40:0] mix;
   logic signed [50:0] pp;
   logic signed [39:0] with_debt;
   logic signed [39:0] new_debt;
   logic signed [31:0] step3;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_step_count = rsp_count_ff;
   assign rsp_step_us = rsp_step_ff;

   always_comb begin
      if (hlen_ff == 6'd0) begin
         len = FW'(1);
      end else if (32'(hlen_ff) > MAX_HISTORY) begin
         len = FW'(MAX_HISTORY);
      end else begin
         len = FW'(hlen_ff);
      end
      tstep = (target_ff == 20'd0) ? 20'd1 : target_ff;
      rate = (blend_ff > BLEND_RATE_ONE) ? BLEND_RATE_ONE : blend_ff;
      need = {2'b00, trim_ff, 1'b1};
      keep = fill_ff - FW'({trim_ff, 1'b0});
      rt = {dr_ff, dq_ff[DW-1]};
      rt_sub = rt - {1'b0, dd_ff};
      if (phase_ff == 2'd1) begin
         mul_a = 33'(signed'(debt_ff));
         mul_b = signed'({2'b00, pay_ff});
      end else begin
         mul_a = 33'(signed'({1'b0, dq_ff[FRAME_W-1:0]}) - signed'({1'b0, frame_ff}));
         mul_b = signed'({1'b0, rate});
      end
      mix = signed'({5'd0, frame_ff, 16'd0}) + mp_ff[40:0] + 41'sd32768;
      pp = (mp_ff + 51'sd2048) >>> 12;
      with_debt = signed'({19'd0, s_ff}) + pp[39:0];
      step3 = sat32(with_debt);
      new_debt = 40'(debt_ff) + signed'({20'd0, frame_ff}) - 40'(step3);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      frame_in = frame_ff;
      fill_in = fill_ff;
      rem_in = rem_ff;
      debt_in = debt_ff;
      cand_in = cand_ff;
      i_in = i_ff;
      j_in = j_ff;
      rank_in = rank_ff;
      sum_in = sum_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      dd_in = dd_ff;
      dcnt_in = dcnt_ff;
      mp_in = mp_ff;
      s_in = s_ff;
      res_count_in = res_count_ff;
      res_step_in = res_step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_step_in = rsp_step_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               frame_in = req_frame_us;
               res_count_in = COUNT_W'(1);
               case (mode_ff)
                  MODE_VARIABLE: begin
                     res_step_in = 32'(req_frame_us);
                     state_in = S_OUT;
                  end
                  MODE_FIXED: begin
                     dq_in = DW'(rem_ff) + DW'(req_frame_us);
                     dr_in = '0;
                     dd_in = DW'(tstep);
                     dcnt_in = '0;
                     state_in = S_DIV;
                  end
                  default: begin
                     fill_in = (fill_ff < len) ? fill_ff + FW'(1) : len;
                     state_in = S_CHK;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (7'(fill_ff) < need) begin
               s_in = {1'b0, frame_ff};
               phase_in = 2'd1;
               state_in = (mode_ff == MODE_PAYBACK) ? S_MUL : S_OUT;
               res_step_in = 32'(frame_ff);
            end else begin
               i_in = '0;
               sum_in = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cand_in = hist_ff[i_ff[IW-1:0]];
            rank_in = '0;
            j_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if ((j_ff < fill_ff) && ((hist_ff[0] < cand_ff)
                  || ((hist_ff[0] == cand_ff) && (j_ff < i_ff)))) begin
               rank_in = rank_ff + FW'(1);
            end
            j_in = j_ff + FW'(1);
            if (j_ff == FW'(MAX_HISTORY - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if ((rank_ff >= FW'(trim_ff)) && (rank_ff < fill_ff - FW'(trim_ff))) begin
               sum_in = sum_ff + SW'(cand_ff);
            end
            i_in = i_ff + FW'(1);
            if (i_ff + FW'(1) == fill_ff) begin
               state_in = S_DIV;
               dq_in = DW'(sum_in) + DW'(keep >> 1);
               dr_in = '0;
               dd_in = DW'(keep);
               dcnt_in = '0;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_DIV: begin
            if (rt >= {1'b0, dd_ff}) begin
               dr_in = rt_sub[DW-1:0];
               dq_in = {dq_ff[DW-2:0], 1'b1};
            end else begin
               dr_in = rt[DW-1:0];
               dq_in = {dq_ff[DW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + CW'(1);
            if (dcnt_ff == CW'(DW - 1)) begin
               if (mode_ff == MODE_FIXED) begin
                  state_in = S_OUT;
                  res_step_in = 32'(tstep);
                  res_count_in = (|dq_in[DW-1:COUNT_W]) ? COUNT_MAX : dq_in[COUNT_W-1:0];
                  rem_in = dr_in[20:0];
               end else begin
                  state_in = S_MUL;
                  phase_in = 2'd0;
               end
            end
         end
         S_MUL: begin
            case (phase_ff)
               2'd0: begin
                  mp_in = 51'(mul_a) * 51'(mul_b);
                  phase_in = 2'd2;
               end
               2'd2: begin
                  s_in = mix[36:16];
                  res_step_in = 32'(mix[36:16]);
                  phase_in = 2'd1;
                  if (mode_ff != MODE_PAYBACK) begin
                     state_in = S_OUT;
                  end
               end
               2'd1: begin
                  mp_in = 51'(mul_a) * 51'(mul_b);
                  phase_in = 2'd3;
               end
               default: begin
                  res_step_in = step3;
                  debt_in = sat32(new_debt);
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_count_ff;
               rsp_step_in = res_step_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_VARIABLE;
         target_ff <= TARGET_STEP_RST;
         hlen_ff <= HISTORY_LEN_RST;
         trim_ff <= '0;
         blend_ff <= BLEND_RATE_ONE;
         pay_ff <= PAYBACK_RATE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_MODE: mode_ff <= csr_wdata[1:0];
            REG_TARGET_STEP: target_ff <= csr_wdata[19:0];
            REG_HISTORY_LEN: hlen_ff <= csr_wdata[5:0];
            REG_TRIM_COUNT: trim_ff <= csr_wdata[3:0];
            REG_BLEND_RATE: blend_ff <= {1'b0, csr_wdata[15:0]} | ((csr_wdata[16]) ?
                                        BLEND_RATE_ONE : 17'd0);
            REG_PAYBACK_RATE: pay_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         fill_ff <= '0;
         rem_ff <= '0;
         debt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         rem_ff <= rem_in;
         debt_ff <= debt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      cand_ff <= cand_in;
      i_ff <= i_in;
      j_ff <= j_in;
      rank_ff <= rank_in;
      sum_ff <= sum_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      dd_ff <= dd_in;
      dcnt_ff <= dcnt_in;
      mp_ff <= mp_in;
      s_ff <= s_in;
      res_count_ff <= res_count_in;
      res_step_ff <= res_step_in;
      rsp_count_ff <= rsp_count_in;
      rsp_step_ff <= rsp_step_in;
   end

   for (genvar k = 0; k < MAX_HISTORY; k++) begin : g_hist
      always_ff @(posedge clock) begin
         if (state_ff == S_SCAN) begin
            hist_ff[k] <= hist_ff[(k + 1) % MAX_HISTORY];
         end else if (accept && (mode_ff[1] == 1'b1)) begin
            if (k == 0) begin
               hist_ff[k] <= req_frame_us;
            end else if (FW'(k) < len) begin
               hist_ff[k] <= hist_ff[(k + MAX_HISTORY - 1) % MAX_HISTORY];
            end
         end
      end
   end

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("Finished item was not moved to the output register.");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(fill_ff) <= MAX_HISTORY))
      else $error("Fill count exceeds the history depth.");
   a_variable_one: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_VARIABLE) |=> (state_ff == S_OUT && res_count_ff == COUNT_W'(1)))
      else $error("Variable mode item did not yield one step.");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !req_ready)
      else $error("Item accepted while the divider is busy.");

endmodule
